// ----- design/ehm_pkg.sv -----
// shared types, codes and defaults of the energy histogram analyzer
`default_nettype none

package ehm_pkg;

    // default sizes, overridable on the top level
    localparam int DEF_CHANNELS     = 16;
    localparam int DEF_FULL_BINS    = 32768;
    localparam int DEF_COARSE_SHIFT = 3;

    // apb register map, 64-bit registers at 8-byte steps
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 64;
    localparam int REG_IDX_LSB = 3;

    localparam logic [1:0] REG_BIN_SHIFTS  = 2'd0;
    localparam logic [1:0] REG_PILEUP_MASK = 2'd1;
    localparam logic [1:0] REG_CH_PER_MOD  = 2'd2;

    localparam logic [3:0] CH_PER_MOD_RESET = 4'd8;

    // operation codes of an input word
    localparam logic [2:0] OP_STREAM    = 3'd0;
    localparam logic [2:0] OP_POLL      = 3'd1;
    localparam logic [2:0] OP_RD_FULL   = 3'd2;
    localparam logic [2:0] OP_RD_COARSE = 3'd3;
    localparam logic [2:0] OP_RD_COUNT  = 3'd4;

    // info word bit positions
    localparam int INFO_MODULE_BIT = 3;
    localparam int INFO_OVER_BIT   = 4;
    localparam int INFO_PILEUP_BIT = 5;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] info_word;
        logic [15:0] energy_word;
        logic [3:0]  channel;
        logic [14:0] bin_index;
    } t_ehm_in;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  channel_out;
        logic [15:0] bin_out;
        logic [31:0] count_value;
    } t_ehm_out;

    typedef struct packed {
        logic [63:0] bin_shifts;
        logic [15:0] pileup_reject_mask;
        logic [3:0]  channels_per_module;
    } t_ehm_cfg;

    typedef enum logic [2:0] {
        KIND_EVENT,
        KIND_RD_FULL,
        KIND_RD_COARSE,
        KIND_RD_COUNT,
        KIND_NOP
    } t_ehm_kind;

    // classified work item handed from front to back
    typedef struct packed {
        t_ehm_kind   kind;
        logic [4:0]  chan;
        logic [15:0] bin;
        logic        full_inc;
        logic        coarse_inc;
        logic        total_inc;
        logic        chan_inc;
        logic        rd_ok;
    } t_ehm_job;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_back_state;

endpackage

`default_nettype wire

// ----- design/ehm_front.sv -----
// front end: input handshake and classification of each word into a job
`default_nettype none

module ehm_front import ehm_pkg::*; #(
    parameter int CHANNELS     = DEF_CHANNELS,
    parameter int FULL_BINS    = DEF_FULL_BINS,
    parameter int COARSE_SHIFT = DEF_COARSE_SHIFT
) (
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ehm_in  i_in_word,
    input  t_ehm_cfg i_cfg,
    input  logic     i_q_full,
    input  logic     i_clearing,
    output logic     o_push,
    output t_ehm_job o_job
);

    localparam int COARSE_BINS = ((FULL_BINS - 1) >> COARSE_SHIFT) + 1;

    logic        s_is_stream;
    logic [4:0]  s_ev_ch;
    logic [3:0]  s_shift;
    logic        s_rej;
    logic        s_pileup;
    logic        s_over;
    logic [15:0] s_ev_bin;
    logic [15:0] s_cbin;
    logic        s_ch_ok;
    logic        s_pass;
    logic        s_bin_ok;
    logic        s_coarse_ok;
    logic        s_rd_ch_ok;
    logic        s_counted;

    assign o_in_stall = i_q_full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall;

    assign s_is_stream = (i_in_word.operation == OP_STREAM);

    // stream channel = low 3 bits plus module offset
    assign s_ev_ch = s_is_stream
        ? (5'(i_in_word.info_word[2:0])
           + (i_in_word.info_word[INFO_MODULE_BIT] ? 5'(i_cfg.channels_per_module) : 5'd0))
        : {1'b0, i_in_word.channel};

    // channels above 15 have no shift and no reject bit
    assign s_shift  = s_ev_ch[4] ? 4'd0 : i_cfg.bin_shifts[{s_ev_ch[3:0], 2'b00} +: 4];
    assign s_rej    = !s_ev_ch[4] && i_cfg.pileup_reject_mask[s_ev_ch[3:0]];
    assign s_pileup = s_is_stream ? i_in_word.info_word[INFO_PILEUP_BIT]
                                  : i_in_word.energy_word[0];
    assign s_over   = s_is_stream && i_in_word.info_word[INFO_OVER_BIT];

    assign s_ev_bin    = {i_in_word.energy_word[15:1], 1'b0} >> s_shift;
    assign s_cbin      = s_ev_bin >> COARSE_SHIFT;
    assign s_ch_ok     = {27'd0, s_ev_ch} < 32'(CHANNELS);
    assign s_pass      = !(s_rej && s_pileup);
    assign s_bin_ok    = {16'd0, s_ev_bin} < 32'(FULL_BINS);
    assign s_coarse_ok = (s_cbin != 16'd0) && ({16'd0, s_cbin} < 32'(COARSE_BINS));
    assign s_rd_ch_ok  = {28'd0, i_in_word.channel} < 32'(CHANNELS);
    assign s_counted   = s_ch_ok && s_pass;

    always_comb begin
        o_job.kind       = KIND_NOP;
        o_job.chan       = {1'b0, i_in_word.channel};
        o_job.bin        = 16'd0;
        o_job.full_inc   = 1'b0;
        o_job.coarse_inc = 1'b0;
        o_job.total_inc  = 1'b0;
        o_job.chan_inc   = 1'b0;
        o_job.rd_ok      = 1'b0;
        unique case (i_in_word.operation)
            OP_STREAM: begin
                o_job.kind       = KIND_EVENT;
                o_job.chan       = s_ev_ch;
                o_job.bin        = s_ev_bin;
                o_job.full_inc   = s_counted && !s_over && s_bin_ok;
                o_job.coarse_inc = s_counted && !s_over && s_bin_ok && s_coarse_ok;
                o_job.total_inc  = 1'b1;
                o_job.chan_inc   = s_ch_ok;
            end
            OP_POLL: begin
                // a rejected polled event leaves every count alone
                o_job.kind       = KIND_EVENT;
                o_job.chan       = s_ev_ch;
                o_job.bin        = s_ev_bin;
                o_job.full_inc   = s_counted && (s_ev_bin != 16'd0) && s_bin_ok;
                o_job.coarse_inc = s_counted && (s_ev_bin != 16'd0) && s_bin_ok
                                   && s_coarse_ok;
                o_job.total_inc  = s_counted;
                o_job.chan_inc   = s_counted;
            end
            OP_RD_FULL: begin
                o_job.kind  = KIND_RD_FULL;
                o_job.bin   = {1'b0, i_in_word.bin_index};
                o_job.rd_ok = s_rd_ch_ok && ({17'd0, i_in_word.bin_index} < 32'(FULL_BINS));
            end
            OP_RD_COARSE: begin
                o_job.kind  = KIND_RD_COARSE;
                o_job.bin   = {1'b0, i_in_word.bin_index};
                o_job.rd_ok = s_rd_ch_ok
                              && ({17'd0, i_in_word.bin_index} < 32'(COARSE_BINS));
            end
            OP_RD_COUNT: begin
                o_job.kind  = KIND_RD_COUNT;
                o_job.rd_ok = s_rd_ch_ok;
            end
            default: begin
                o_job.kind = KIND_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/ehm_queue.sv -----
// two-entry job queue between front and back
`default_nettype none

module ehm_queue import ehm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_ehm_job i_job,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_ehm_job o_head
);

    t_ehm_job          r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              s_push;
    logic              s_pop;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (s_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + (QPTR_W + 1)'(1);
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/ehm_back.sv -----
// back end: histogram memories, counters, read-modify-write and result register
`default_nettype none

module ehm_back import ehm_pkg::*; #(
    parameter int CHANNELS     = DEF_CHANNELS,
    parameter int FULL_BINS    = DEF_FULL_BINS,
    parameter int COARSE_SHIFT = DEF_COARSE_SHIFT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_empty,
    input  t_ehm_job i_head,
    output logic     o_pop,
    output logic     o_clearing,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ehm_out o_out_word
);

    localparam int COARSE_BINS  = ((FULL_BINS - 1) >> COARSE_SHIFT) + 1;
    localparam int FULL_DEPTH   = CHANNELS * FULL_BINS;
    localparam int COARSE_DEPTH = CHANNELS * COARSE_BINS;
    localparam int FULL_AW      = $clog2(FULL_DEPTH);
    localparam int COARSE_AW    = $clog2(COARSE_DEPTH);
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [FULL_AW-1:0]   r_clr_cnt;
    t_ehm_job             r_job;
    logic [FULL_AW-1:0]   r_full_addr;
    logic [COARSE_AW-1:0] r_coarse_addr;
    logic [31:0]          r_full_mem [FULL_DEPTH];
    logic [31:0]          r_coarse_mem [COARSE_DEPTH];
    logic [31:0]          r_full_rd;
    logic [31:0]          r_coarse_rd;
    logic [31:0]          r_total;
    logic [31:0]          r_cnt [CHANNELS];
    logic                 r_out_valid;
    t_ehm_out             r_out;

    logic [15:0]          s_head_cbin;
    logic [FULL_AW-1:0]   s_head_full_addr;
    logic [COARSE_AW-1:0] s_head_coarse_addr;
    logic                 s_clr_last;
    logic                 s_pop;
    logic                 s_load;
    logic                 s_full_we;
    logic                 s_coarse_we;
    logic [FULL_AW-1:0]   s_full_wa;
    logic [COARSE_AW-1:0] s_coarse_wa;
    logic [31:0]          s_full_wd;
    logic [31:0]          s_coarse_wd;
    logic [CH_W-1:0]      s_cnt_idx;
    t_ehm_out             s_result;

    // coarse reads use the bin index as is, events the shifted bin
    assign s_head_cbin = (i_head.kind == KIND_RD_COARSE) ? i_head.bin
                                                         : (i_head.bin >> COARSE_SHIFT);
    assign s_head_full_addr = FULL_AW'(32'(i_head.chan) * 32'(FULL_BINS)
                                       + 32'(i_head.bin));
    assign s_head_coarse_addr = COARSE_AW'(32'(i_head.chan) * 32'(COARSE_BINS)
                                           + 32'(s_head_cbin));

    assign s_clr_last = (r_clr_cnt == FULL_AW'(FULL_DEPTH - 1));
    assign s_cnt_idx  = r_job.chan[CH_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (s_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_pop       = 1'b0;
        s_load      = 1'b0;
        s_full_we   = 1'b0;
        s_coarse_we = 1'b0;
        s_full_wa   = r_full_addr;
        s_coarse_wa = r_coarse_addr;
        s_full_wd   = r_full_rd + 32'd1;
        s_coarse_wd = r_coarse_rd + 32'd1;
        unique case (r_state)
            ST_CLEAR: begin
                s_full_we   = 1'b1;
                s_coarse_we = 32'(r_clr_cnt) < 32'(COARSE_DEPTH);
                s_full_wa   = r_clr_cnt;
                s_coarse_wa = r_clr_cnt[COARSE_AW-1:0];
                s_full_wd   = 32'd0;
                s_coarse_wd = 32'd0;
            end
            ST_IDLE: begin
                s_pop = !i_q_empty;
            end
            ST_EXEC: begin
                s_load      = !r_out_valid || !i_out_stall;
                s_full_we   = s_load && r_job.full_inc;
                s_coarse_we = s_load && r_job.coarse_inc;
            end
            default: begin
                s_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + FULL_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_pop) begin
            r_job         <= i_head;
            r_full_addr   <= s_head_full_addr;
            r_coarse_addr <= s_head_coarse_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_full_we) begin
            r_full_mem[s_full_wa] <= s_full_wd;
        end
        if (s_pop) begin
            r_full_rd <= r_full_mem[s_head_full_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_coarse_we) begin
            r_coarse_mem[s_coarse_wa] <= s_coarse_wd;
        end
        if (s_pop) begin
            r_coarse_rd <= r_coarse_mem[s_head_coarse_addr];
        end
    end

    always_comb begin
        s_result.accepted    = r_job.full_inc;
        s_result.channel_out = r_job.chan[3:0];
        s_result.bin_out     = r_job.bin;
        s_result.count_value = 32'd0;
        unique case (r_job.kind)
            KIND_EVENT:     s_result.count_value = r_total + {31'd0, r_job.total_inc};
            KIND_RD_FULL:   s_result.count_value = r_job.rd_ok ? r_full_rd : 32'd0;
            KIND_RD_COARSE: s_result.count_value = r_job.rd_ok ? r_coarse_rd : 32'd0;
            KIND_RD_COUNT:  s_result.count_value = r_job.rd_ok ? r_cnt[s_cnt_idx] : 32'd0;
            KIND_NOP:       s_result.count_value = 32'd0;
            default:        s_result.count_value = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (s_load) begin
            if (r_job.total_inc) begin
                r_total <= r_total + 32'd1;
            end
            if (r_job.chan_inc) begin
                r_cnt[s_cnt_idx] <= r_cnt[s_cnt_idx] + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out <= s_result;
        end
    end

    assign o_pop       = s_pop;
    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ----- design/energy_histogram_mca_core.sv -----
// top level of the per-channel energy histogram analyzer
//
//  channel   direction  handshake              word
//  in        in         i_in_valid/o_in_stall  i_in_word  (t_ehm_in)
//  out       out        o_out_valid/i_out_stall o_out_word (t_ehm_out)
//  config    in/out     apb psel/penable       paddr, pwdata, prdata (64 bit)
//
// in the back end the idle state reads both histogram memories at a word's
// bins, and the exec state, once the result register is free, writes the
// incremented counts and loads the result register; the single
// read-modify-write path sets the rate, one word at a time.
// after reset a clearing pass zeroes the memories, one entry per cycle over
// all CHANNELS*FULL_BINS entries (524288 at the default sizes); o_in_stall is high
// meanwhile, configuration writes are taken as ever.
// a two-word queue takes input words while a result waits on i_out_stall, until it is full.
`default_nettype none

module energy_histogram_mca_core import ehm_pkg::*; #(
    parameter int CHANNELS     = DEF_CHANNELS,
    parameter int FULL_BINS    = DEF_FULL_BINS,
    parameter int COARSE_SHIFT = DEF_COARSE_SHIFT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_ehm_in           i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_ehm_out          o_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_ehm_cfg   r_cfg;
    logic       s_cfg_wr;
    logic [1:0] s_reg_idx;
    logic       s_push;
    t_ehm_job   s_job;
    logic       s_q_full;
    logic       s_q_empty;
    logic       s_pop;
    t_ehm_job   s_head;
    logic       s_clearing;

    assign pready    = 1'b1;
    assign s_cfg_wr  = psel && penable && pwrite;
    assign s_reg_idx = paddr[APB_AW-1:REG_IDX_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_shifts          <= '0;
            r_cfg.pileup_reject_mask  <= '0;
            r_cfg.channels_per_module <= CH_PER_MOD_RESET;
        end else if (s_cfg_wr) begin
            unique case (s_reg_idx)
                REG_BIN_SHIFTS:  r_cfg.bin_shifts          <= pwdata;
                REG_PILEUP_MASK: r_cfg.pileup_reject_mask  <= pwdata[15:0];
                REG_CH_PER_MOD:  r_cfg.channels_per_module <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (s_reg_idx)
            REG_BIN_SHIFTS:  prdata = r_cfg.bin_shifts;
            REG_PILEUP_MASK: prdata = {48'd0, r_cfg.pileup_reject_mask};
            REG_CH_PER_MOD:  prdata = {60'd0, r_cfg.channels_per_module};
            default:         prdata = '0;
        endcase
    end

    ehm_front #(
        .CHANNELS     (CHANNELS),
        .FULL_BINS    (FULL_BINS),
        .COARSE_SHIFT (COARSE_SHIFT)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_cfg      (r_cfg),
        .i_q_full   (s_q_full),
        .i_clearing (s_clearing),
        .o_push     (s_push),
        .o_job      (s_job)
    );

    ehm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_job   (s_job),
        .o_full  (s_q_full),
        .i_pop   (s_pop),
        .o_empty (s_q_empty),
        .o_head  (s_head)
    );

    ehm_back #(
        .CHANNELS     (CHANNELS),
        .FULL_BINS    (FULL_BINS),
        .COARSE_SHIFT (COARSE_SHIFT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (s_q_empty),
        .i_head      (s_head),
        .o_pop       (s_pop),
        .o_clearing  (s_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ----- design/ehm_checker.sv -----
// port-level checks of the energy histogram analyzer, bound to the top level
`default_nettype none

module ehm_checker import ehm_pkg::*; #(
    parameter int FULL_BINS = DEF_FULL_BINS
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input t_ehm_in           i_in_word,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_ehm_out          o_out_word,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready
);

    // a held result word keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // a stalled input word stays on the port unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed while stalled");

    // a counted histogram bin always lies inside the full histogram
    a_accept_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.accepted |-> 32'(o_out_word.bin_out) < 32'(FULL_BINS))
        else $error("accepted event with bin outside the histogram");

    // memories are being cleared right after reset, so no word is taken
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("input taken before the clearing pass");

    // bin shift register reads back what was written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready
         && paddr[APB_AW-1:REG_IDX_LSB] == REG_BIN_SHIFTS)
        ##1 (paddr[APB_AW-1:REG_IDX_LSB] == REG_BIN_SHIFTS)
        |-> prdata == $past(pwdata))
        else $error("bin shift register readback mismatch");

endmodule

bind energy_histogram_mca_core ehm_checker #(
    .FULL_BINS (FULL_BINS)
) u_ehm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

`default_nettype wire

// ----- verif/tb_energy_histogram_mca_core.sv -----
// self-checking testbench of the energy histogram analyzer core
`timescale 1ns / 100ps

module tb_energy_histogram_mca_core;
    import ehm_pkg::*;

    localparam int N_CH        = DEF_CHANNELS;
    localparam int N_BINS      = DEF_FULL_BINS;
    localparam int C_SHIFT     = DEF_COARSE_SHIFT;
    localparam int N_COARSE    = ((N_BINS - 1) >> C_SHIFT) + 1;
    localparam int COARSE_BASE = N_CH * N_BINS;   // key offset of the coarse bins
    localparam int HIT_KEEP    = 64;
    localparam int MAX_WAIT    = 12;
    localparam int HOLD_OFF    = 400;
    localparam int DRAIN_CYC   = 6;
    localparam int CYCLE_LIMIT = 2_000_000;       // must outlast the clearing pass

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    class histo_scoreboard;
        bit [63:0] bin_shifts;
        bit [15:0] pileup_mask;
        bit [3:0]  ch_per_mod;
        bit [31:0] bin_counts[int];   // full and coarse histogram entries
        bit [31:0] chan_events[N_CH];
        bit [31:0] total_events;
        t_ehm_out  expected_words[$];
        int        recent_hits[$];
        int        errors;
        int        checked;
        int        hits;

        function new();
            bin_shifts   = '0;
            pileup_mask  = '0;
            ch_per_mod   = CH_PER_MOD_RESET;
            total_events = '0;
            errors       = 0;
            checked      = 0;
            hits         = 0;
            foreach (chan_events[i]) chan_events[i] = '0;
        endfunction

        function bit [31:0] count_at(int key);
            return bin_counts.exists(key) ? bin_counts[key] : 32'd0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                REG_BIN_SHIFTS:  bin_shifts  = value;
                REG_PILEUP_MASK: pileup_mask = value[15:0];
                REG_CH_PER_MOD:  ch_per_mod  = value[3:0];
                default: ;
            endcase
        endfunction

        function void note_word(t_ehm_in w);
            t_ehm_out   r;
            logic [4:0] ch;
            logic [3:0] sh;
            logic       pileup;
            logic       over;
            logic       known;
            logic       pass;
            int         key;
            r      = '0;
            ch     = {1'b0, w.channel};
            pileup = 1'b0;
            over   = 1'b0;
            if (w.operation == OP_STREAM || w.operation == OP_POLL) begin
                if (w.operation == OP_STREAM) begin
                    ch = 5'(w.info_word[2:0])
                       + (w.info_word[INFO_MODULE_BIT] ? 5'(ch_per_mod) : 5'd0);
                    over   = w.info_word[INFO_OVER_BIT];
                    pileup = w.info_word[INFO_PILEUP_BIT];
                end else begin
                    pileup = w.energy_word[0];
                end
                known     = (ch < N_CH);
                sh        = known ? bin_shifts[4*ch +: 4] : 4'd0;
                r.bin_out = {w.energy_word[15:1], 1'b0} >> sh;
                pass      = !(known && pileup_mask[ch[3:0]] && pileup);
                // stream words drop on overflow, polled words need a nonzero bin
                if (known && pass && r.bin_out < N_BINS &&
                    (w.operation == OP_STREAM ? !over : r.bin_out != 0)) begin
                    r.accepted = 1'b1;
                    key = int'(ch) * N_BINS + int'(r.bin_out);
                    bin_counts[key] = count_at(key) + 1;
                    if ((r.bin_out >> C_SHIFT) != 0) begin
                        key = COARSE_BASE + int'(ch) * N_COARSE + int'(r.bin_out >> C_SHIFT);
                        bin_counts[key] = count_at(key) + 1;
                    end
                    recent_hits.push_back(int'(ch) * 65536 + int'(r.bin_out));
                    if (recent_hits.size() > HIT_KEEP) void'(recent_hits.pop_front());
                    hits++;
                end
                // stream words always count, polled ones only on a known channel past the pileup check
                if (w.operation == OP_STREAM || (known && pass)) begin
                    total_events++;
                    if (known) chan_events[ch[3:0]]++;
                end
                r.count_value = total_events;
            end else if (w.operation == OP_RD_FULL) begin
                r.bin_out = 16'(w.bin_index);
                if (ch < N_CH && w.bin_index < N_BINS)
                    r.count_value = count_at(int'(ch) * N_BINS + int'(w.bin_index));
            end else if (w.operation == OP_RD_COARSE) begin
                r.bin_out = 16'(w.bin_index);
                if (ch < N_CH && w.bin_index < N_COARSE)
                    r.count_value = count_at(COARSE_BASE + int'(ch) * N_COARSE
                                             + int'(w.bin_index));
            end else if (w.operation == OP_RD_COUNT) begin
                if (ch < N_CH) r.count_value = chan_events[ch[3:0]];
            end
            r.channel_out = ch[3:0];
            expected_words.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 50) $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_ehm_out got);
            t_ehm_out want;
            if (expected_words.size() == 0) begin
                report($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = expected_words.pop_front();
            if (got.accepted !== want.accepted)
                report($sformatf("word %0d accepted: got %0b, expected %0b",
                                 checked, got.accepted, want.accepted));
            if (got.channel_out !== want.channel_out)
                report($sformatf("word %0d channel_out: got %0d, expected %0d",
                                 checked, got.channel_out, want.channel_out));
            if (got.bin_out !== want.bin_out)
                report($sformatf("word %0d bin_out: got %h, expected %h",
                                 checked, got.bin_out, want.bin_out));
            if (got.count_value !== want.count_value)
                report($sformatf("word %0d count_value: got %h, expected %h",
                                 checked, got.count_value, want.count_value));
            checked++;
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_ehm_in           i_in_word   = '0;
    logic              i_out_stall = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_ehm_out          o_out_word;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    histo_scoreboard sb;
    bit send_idle_off = 1'b0;
    bit recv_idle_off = 1'b0;
    bit hold_req      = 1'b0;
    int words_in      = 0;
    int reg_writes    = 0;

    energy_histogram_mca_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_word(i_in_word);
            words_in++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
    end

    // output side: random stall per word, one long hold-off on request
    initial begin : result_sink
        int n;
        forever begin
            if (hold_req) begin
                n        = HOLD_OFF;
                hold_req = 1'b0;
            end else begin
                n = recv_idle_off ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words still expected",
                 cycles, sb.expected_words.size());
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'(idx) << REG_IDX_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    task automatic write_config(input logic [63:0] shifts, input logic [15:0] mask,
                                input logic [3:0] per_mod);
        write_reg(REG_BIN_SHIFTS, shifts);
        write_reg(REG_PILEUP_MASK, 64'(mask));
        write_reg(REG_CH_PER_MOD, 64'(per_mod));
    endtask

    task automatic send_word(input t_ehm_in w);
        int gap;
        gap = send_idle_off ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_fields(input logic [2:0] op, input logic [15:0] info,
                               input logic [15:0] energy, input logic [3:0] ch,
                               input logic [14:0] bidx);
        t_ehm_in w;
        w.operation   = op;
        w.info_word   = info;
        w.energy_word = energy;
        w.channel     = ch;
        w.bin_index   = bidx;
        send_word(w);
    endtask

    // wait until every expected word has come back and the pipe is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic t_ehm_in random_word();
        t_ehm_in w;
        int      pick;
        int      hit;
        w.info_word   = 16'($urandom);
        w.energy_word = 16'($urandom);
        w.channel     = 4'($urandom);
        w.bin_index   = 15'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            w.operation = OP_STREAM;
            w.info_word[INFO_OVER_BIT]   = ($urandom_range(0, 7) == 0);
            w.info_word[INFO_PILEUP_BIT] = ($urandom_range(0, 3) == 0);
            // low energies so that bins get hit more than once
            if ($urandom_range(0, 1) != 0) w.energy_word = 16'($urandom_range(0, 511));
        end else if (pick < 60) begin
            w.operation = OP_POLL;
            if ($urandom_range(0, 1) != 0) w.energy_word[15:1] = 15'($urandom_range(0, 255));
            w.energy_word[0] = ($urandom_range(0, 3) == 0);
        end else if (pick < 93) begin
            case ($urandom_range(0, 2))
                0:       w.operation = OP_RD_FULL;
                1:       w.operation = OP_RD_COARSE;
                default: w.operation = OP_RD_COUNT;
            endcase
            if (sb.recent_hits.size() != 0 && $urandom_range(0, 3) != 0) begin
                hit = sb.recent_hits[$urandom_range(0, sb.recent_hits.size() - 1)];
                w.channel   = 4'(hit >> 16);
                w.bin_index = 15'(hit & 16'hFFFF);
                if (w.operation == OP_RD_COARSE) w.bin_index = w.bin_index >> C_SHIFT;
            end
        end else begin
            w.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return w;
    endfunction

    task automatic run_phase(input int n_words);
        repeat (n_words) send_word(random_word());
        settle();
    endtask

    task automatic random_config();
        write_config({$urandom, $urandom}, 16'($urandom), 4'($urandom_range(1, 8)));
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: channel 0 shift 0, channel 1 shift 15, channel 2 shift 3
        write_config(64'h1111_1111_1111_13F0, 16'hAAAA, 4'd8);
        send_fields(OP_STREAM, 16'h0000, 16'hFFFF, 4'd0, 15'd0);    // bin past the end
        send_fields(OP_STREAM, 16'h0000, 16'h0001, 4'd0, 15'd0);    // bin zero
        send_fields(OP_STREAM, 16'h0000, 16'h7FFF, 4'd0, 15'd0);    // top bin
        send_fields(OP_STREAM, 16'h0001, 16'hFFFF, 4'd0, 15'd0);    // largest shift
        send_fields(OP_STREAM, 16'h0021, 16'h0400, 4'd0, 15'd0);    // pileup rejected
        send_fields(OP_STREAM, 16'h0022, 16'h0040, 4'd0, 15'd0);    // pileup let through
        send_fields(OP_STREAM, 16'h0010, 16'h0100, 4'd0, 15'd0);    // overflow
        send_fields(OP_STREAM, 16'h000F, 16'h1234, 4'd0, 15'd0);    // module bit, channel 15
        send_fields(OP_STREAM, 16'hFFC8, 16'hABCD, 4'd0, 15'd0);    // junk in upper info bits
        send_fields(OP_POLL, 16'h0000, 16'h0000, 4'd0, 15'd0);      // polled bin zero
        send_fields(OP_POLL, 16'h0000, 16'h0001, 4'd0, 15'd0);      // pileup, not masked
        send_fields(OP_POLL, 16'hFFFF, 16'h0011, 4'd3, 15'd0);      // pileup rejected
        send_fields(OP_POLL, 16'h0000, 16'hFFFE, 4'd2, 15'h7FFF);
        send_fields(OP_POLL, 16'h0000, 16'hFFFE, 4'd0, 15'd0);      // bin past the end
        send_fields(OP_RD_FULL, 16'h0000, 16'h0000, 4'd0, 15'd0);
        send_fields(OP_RD_FULL, 16'h0000, 16'h0000, 4'd0, 15'h7FFE);
        send_fields(OP_RD_FULL, 16'h0000, 16'h0000, 4'd2, 15'd8);
        send_fields(OP_RD_FULL, 16'hFFFF, 16'hFFFF, 4'd15, 15'h7FFF);
        send_fields(OP_RD_COARSE, 16'h0000, 16'h0000, 4'd2, 15'd1);
        send_fields(OP_RD_COARSE, 16'h0000, 16'h0000, 4'd0, 15'(N_COARSE - 1));
        send_fields(OP_RD_COARSE, 16'h0000, 16'h0000, 4'd0, 15'h7FFF); // beyond coarse range
        send_fields(OP_RD_COUNT, 16'h0000, 16'h0000, 4'd0, 15'd0);
        send_fields(OP_RD_COUNT, 16'h0000, 16'h0000, 4'd15, 15'h7FFF);
        send_fields(OP_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 4'd10, 15'h7FFF);
        send_fields(OP_SPARE_LAST, 16'h0000, 16'h0000, 4'd5, 15'd0);
        settle();

        write_config(64'd0, 16'h0000, 4'd1);
        run_phase(320);
        write_config({64{1'b1}}, 16'hFFFF, 4'd8);
        run_phase(320);

        random_config();
        send_idle_off = 1'b1;
        recv_idle_off = 1'b1;
        run_phase(300);
        recv_idle_off = 1'b0;

        // receiver holds off while words keep coming, the input has to stall
        random_config();
        hold_req = 1'b1;
        repeat (120) send_word(random_word());
        send_idle_off = 1'b0;
        run_phase(200);

        random_config();
        run_phase(340);
        random_config();
        run_phase(340);

        $display("covered %0d input words and %0d checked results, %0d events histogrammed",
                 words_in, sb.checked, sb.hits);
        $display("%0d register writes over seven settings, one %0d-cycle output hold-off",
                 reg_writes, HOLD_OFF);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ehm_pkg.sv
design/ehm_front.sv
design/ehm_queue.sv
design/ehm_back.sv
design/energy_histogram_mca_core.sv
design/ehm_checker.sv
verif/tb_energy_histogram_mca_core.sv
